// ----- src/pmx_pkg.sv -----
// ----------------------------------------------------------------------------
// pmx_pkg
// Shared types and constants of the partially matched crossover block.
// ----------------------------------------------------------------------------
package pmx_pkg;

   // cut points arrive as fixed 6-bit positions
   localparam int CUT_BITS = 6;

   // sequencer states
   typedef enum logic [3:0] {
      ST_INIT,       // clear both maps after reset
      ST_IDLE,       // load gene pairs
      ST_SEG_RD,     // read segment position
      ST_SEG_WR,     // build maps, emit segment word
      ST_OUT_RD,     // pick next outside position
      ST_OUT_FETCH,  // start both chain walks
      ST_WALK,       // follow maps until unmapped
      ST_CLR_RD,     // read segment position for map cleanup
      ST_CLR_WR      // drop map entries of the run
   } state_type;

endpackage

// ----- src/pmx_map_ram.sv -----
// ----------------------------------------------------------------------------
// pmx_map_ram
// Gene map memory: one write port, one read port, registered read data.
// Each word holds a valid flag on top of the mapped gene.
// ----------------------------------------------------------------------------
module pmx_map_ram #(
   parameter int ADDR_BITS = 8,
   parameter int DATA_BITS = 9
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/pmx_crossover.sv -----
// ----------------------------------------------------------------------------
// pmx_crossover
// Partially matched crossover of two parent permutations loaded one gene
// pair per word; emits the children as one gene pair per result word.
// ----------------------------------------------------------------------------
//  channel   ports                         handshake
//  request   req_gene_a/b, req_cut_*,      taken when start=1 and busy=0
//            req_last_gene
//  response  rsp_child_*, rsp_chain_error, one cycle per word, rsp_valid=1,
//            rsp_last_child_gene           no back-pressure
//
//  After reset both maps are cleared, one entry a cycle, while busy stays
//  high. The last word starts the run: each segment position is read, then
//  written to both maps and emitted; each outside position is read, starts
//  both chain walks and is emitted once they end; then each segment position
//  is read again to drop its map entries. busy is high from the last word
//  until cleanup ends. Result words are never held back.
// ----------------------------------------------------------------------------
module pmx_crossover
   import pmx_pkg::*;
#(
   parameter int MAX_LEN   = 64,
   parameter int GENE_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [GENE_BITS-1:0] req_gene_a,
   input  logic [GENE_BITS-1:0] req_gene_b,
   input  logic [CUT_BITS-1:0]  req_cut_first,
   input  logic [CUT_BITS-1:0]  req_cut_second,
   input  logic                 req_last_gene,
   output logic                 rsp_valid,
   output logic [GENE_BITS-1:0] rsp_child_a_gene,
   output logic [GENE_BITS-1:0] rsp_child_b_gene,
   output logic                 rsp_chain_error,
   output logic                 rsp_last_child_gene
);

   localparam int CNT_BITS = $clog2(MAX_LEN + 1);
   localparam int IDX_BITS = $clog2(MAX_LEN);
   localparam int CMP_BITS = (CNT_BITS > CUT_BITS) ? CNT_BITS : CUT_BITS;
   localparam int MAP_BITS = GENE_BITS + 1;

   // control registers
   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [CNT_BITS-1:0]   len_ff, len_in;
   logic [CNT_BITS-1:0]   lo_ff, lo_in;
   logic [CNT_BITS-1:0]   hi_ff, hi_in;
   logic [CNT_BITS-1:0]   pos_ff, pos_in;
   logic [CNT_BITS-1:0]   k_ff, k_in;
   logic [CNT_BITS-1:0]   steps_ff, steps_in;
   logic [GENE_BITS-1:0]  init_addr_ff, init_addr_in;
   logic                  done_a_ff, done_a_in;
   logic                  done_b_ff, done_b_in;
   logic                  err_ff, err_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [GENE_BITS-1:0]  chain_a_ff, chain_a_in;
   logic [GENE_BITS-1:0]  chain_b_ff, chain_b_in;
   logic [GENE_BITS-1:0]  rsp_a_ff, rsp_a_in;
   logic [GENE_BITS-1:0]  rsp_b_ff, rsp_b_in;
   logic                  rsp_err_ff, rsp_err_in;
   logic                  rsp_last_ff, rsp_last_in;

   // parent stores
   logic [GENE_BITS-1:0]  store_a_mem [MAX_LEN];
   logic [GENE_BITS-1:0]  store_b_mem [MAX_LEN];
   logic [GENE_BITS-1:0]  store_a_rd_ff;
   logic [GENE_BITS-1:0]  store_b_rd_ff;

   // map ports: map_a keyed by parent b gene, map_b keyed by parent a gene
   logic                  map_a_wr_en, map_b_wr_en;
   logic [GENE_BITS-1:0]  map_a_wr_addr, map_b_wr_addr;
   logic [MAP_BITS-1:0]   map_a_wr_data, map_b_wr_data;
   logic [GENE_BITS-1:0]  map_a_rd_addr, map_b_rd_addr;
   logic [MAP_BITS-1:0]   map_a_rd_data, map_b_rd_data;

   // load and cut handling
   logic                  accept;
   logic                  load_ok;
   logic [CNT_BITS-1:0]   len_new;
   logic [CMP_BITS-1:0]   cut_x, cut_y, cut_lo, cut_hi, len_ext;
   logic                  last_pos;

   assign accept  = start && (state_ff == ST_IDLE);
   assign load_ok = count_ff < CNT_BITS'(MAX_LEN);
   assign len_new = count_ff + CNT_BITS'(load_ok);

   // order the cuts, then clamp both to the loaded length
   always_comb begin
      cut_x   = CMP_BITS'(req_cut_first);
      cut_y   = CMP_BITS'(req_cut_second);
      len_ext = CMP_BITS'(len_new);
      cut_lo  = (cut_x > cut_y) ? cut_y : cut_x;
      cut_hi  = (cut_x > cut_y) ? cut_x : cut_y;
      if (cut_lo > len_ext) begin
         cut_lo = len_ext;
      end
      if (cut_hi > len_ext) begin
         cut_hi = len_ext;
      end
   end

   assign last_pos = (k_ff + CNT_BITS'(1)) == len_ff;

   // parent store write at the load position, read at the current position
   always_ff @(posedge clock) begin
      if (accept && load_ok) begin
         store_a_mem[count_ff[IDX_BITS-1:0]] <= req_gene_a;
         store_b_mem[count_ff[IDX_BITS-1:0]] <= req_gene_b;
      end
      store_a_rd_ff <= store_a_mem[pos_ff[IDX_BITS-1:0]];
      store_b_rd_ff <= store_b_mem[pos_ff[IDX_BITS-1:0]];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      len_in       = len_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      steps_in     = steps_ff;
      init_addr_in = init_addr_ff;
      done_a_in    = done_a_ff;
      done_b_in    = done_b_ff;
      err_in       = err_ff;
      chain_a_in   = chain_a_ff;
      chain_b_in   = chain_b_ff;
      rsp_valid_in = 1'b0;
      rsp_a_in     = rsp_a_ff;
      rsp_b_in     = rsp_b_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;

      map_a_wr_en   = 1'b0;
      map_b_wr_en   = 1'b0;
      map_a_wr_addr = store_b_rd_ff;
      map_b_wr_addr = store_a_rd_ff;
      map_a_wr_data = '0;
      map_b_wr_data = '0;
      map_a_rd_addr = chain_b_ff;
      map_b_rd_addr = chain_a_ff;

      case (state_ff)
         ST_INIT: begin
            map_a_wr_en   = 1'b1;
            map_b_wr_en   = 1'b1;
            map_a_wr_addr = init_addr_ff;
            map_b_wr_addr = init_addr_ff;
            init_addr_in  = init_addr_ff + GENE_BITS'(1);
            if (init_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               count_in = len_new;
               if (req_last_gene) begin
                  len_in   = len_new;
                  lo_in    = CNT_BITS'(cut_lo);
                  hi_in    = CNT_BITS'(cut_hi);
                  pos_in   = CNT_BITS'(cut_lo);
                  k_in     = '0;
                  state_in = ST_SEG_RD;
               end
            end
         end
         ST_SEG_RD: begin
            if (pos_ff == hi_ff) begin
               pos_in   = '0;
               state_in = ST_OUT_RD;
            end else begin
               state_in = ST_SEG_WR;
            end
         end
         ST_SEG_WR: begin
            // later segment positions overwrite earlier map entries
            map_a_wr_en   = 1'b1;
            map_b_wr_en   = 1'b1;
            map_a_wr_data = {1'b1, store_a_rd_ff};
            map_b_wr_data = {1'b1, store_b_rd_ff};
            rsp_valid_in  = 1'b1;
            rsp_a_in      = store_a_rd_ff;
            rsp_b_in      = store_b_rd_ff;
            rsp_err_in    = 1'b0;
            rsp_last_in   = last_pos;
            k_in          = k_ff + CNT_BITS'(1);
            pos_in        = pos_ff + CNT_BITS'(1);
            state_in      = ST_SEG_RD;
         end
         ST_OUT_RD: begin
            if (pos_ff == len_ff) begin
               pos_in   = lo_ff;
               state_in = ST_CLR_RD;
            end else if (pos_ff >= lo_ff && pos_ff < hi_ff) begin
               // skip over the segment
               pos_in = hi_ff;
            end else begin
               state_in = ST_OUT_FETCH;
            end
         end
         ST_OUT_FETCH: begin
            // child a follows map_b from the parent b gene, child b map_a
            chain_a_in    = store_b_rd_ff;
            chain_b_in    = store_a_rd_ff;
            map_b_rd_addr = store_b_rd_ff;
            map_a_rd_addr = store_a_rd_ff;
            steps_in      = '0;
            done_a_in     = 1'b0;
            done_b_in     = 1'b0;
            err_in        = 1'b0;
            state_in      = ST_WALK;
         end
         ST_WALK: begin
            // both walks step in lockstep until each is unmapped or exceeds the length
            if (!done_a_ff) begin
               if (map_b_rd_data[GENE_BITS]) begin
                  if (steps_ff >= len_ff) begin
                     err_in    = 1'b1;
                     done_a_in = 1'b1;
                  end else begin
                     chain_a_in = map_b_rd_data[GENE_BITS-1:0];
                  end
               end else begin
                  done_a_in = 1'b1;
               end
            end
            if (!done_b_ff) begin
               if (map_a_rd_data[GENE_BITS]) begin
                  if (steps_ff >= len_ff) begin
                     err_in    = 1'b1;
                     done_b_in = 1'b1;
                  end else begin
                     chain_b_in = map_a_rd_data[GENE_BITS-1:0];
                  end
               end else begin
                  done_b_in = 1'b1;
               end
            end
            map_b_rd_addr = chain_a_in;
            map_a_rd_addr = chain_b_in;
            if (!done_a_in || !done_b_in) begin
               steps_in = steps_ff + CNT_BITS'(1);
            end else begin
               rsp_valid_in = 1'b1;
               rsp_a_in     = chain_a_in;
               rsp_b_in     = chain_b_in;
               rsp_err_in   = err_in;
               rsp_last_in  = last_pos;
               k_in         = k_ff + CNT_BITS'(1);
               pos_in       = pos_ff + CNT_BITS'(1);
               state_in     = ST_OUT_RD;
            end
         end
         ST_CLR_RD: begin
            if (pos_ff == hi_ff) begin
               count_in = '0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_CLR_WR;
            end
         end
         ST_CLR_WR: begin
            // only segment genes were ever mapped
            map_a_wr_en = 1'b1;
            map_b_wr_en = 1'b1;
            pos_in      = pos_ff + CNT_BITS'(1);
            state_in    = ST_CLR_RD;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         count_ff     <= '0;
         len_ff       <= '0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         pos_ff       <= '0;
         k_ff         <= '0;
         steps_ff     <= '0;
         init_addr_ff <= '0;
         done_a_ff    <= 1'b0;
         done_b_ff    <= 1'b0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         len_ff       <= len_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         pos_ff       <= pos_in;
         k_ff         <= k_in;
         steps_ff     <= steps_in;
         init_addr_ff <= init_addr_in;
         done_a_ff    <= done_a_in;
         done_b_ff    <= done_b_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      chain_a_ff  <= chain_a_in;
      chain_b_ff  <= chain_b_in;
      rsp_a_ff    <= rsp_a_in;
      rsp_b_ff    <= rsp_b_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_last_ff <= rsp_last_in;
   end

   // gene maps
   pmx_map_ram #(
      .ADDR_BITS (GENE_BITS),
      .DATA_BITS (MAP_BITS)
   ) u_map_a (
      .clock   (clock),
      .wr_en   (map_a_wr_en),
      .wr_addr (map_a_wr_addr),
      .wr_data (map_a_wr_data),
      .rd_addr (map_a_rd_addr),
      .rd_data (map_a_rd_data)
   );

   pmx_map_ram #(
      .ADDR_BITS (GENE_BITS),
      .DATA_BITS (MAP_BITS)
   ) u_map_b (
      .clock   (clock),
      .wr_en   (map_b_wr_en),
      .wr_addr (map_b_wr_addr),
      .wr_data (map_b_wr_data),
      .rd_addr (map_b_rd_addr),
      .rd_data (map_b_rd_data)
   );

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_child_a_gene    = rsp_a_ff;
   assign rsp_child_b_gene    = rsp_b_ff;
   assign rsp_chain_error     = rsp_err_ff;
   assign rsp_last_child_gene = rsp_last_ff;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of pmx_crossover. Gene pairs are loaded as request words, and
// every last word starts a crossover run. A directed table covers the field
// extremes, cut ordering and clamping, the empty segment, duplicate segment
// genes and an endless map chain. Random runs follow, mostly valid
// permutations with random content, plus overfull and corrupted parents.
// Each result word is checked against typed words or a testbench predictor.
// ----------------------------------------------------------------------------
module tb
   import pmx_pkg::*;
;

   localparam int MAX_LEN        = 64;
   localparam int GENE_W         = 8;
   localparam int MAP_DEPTH      = 1 << GENE_W;
   localparam int DIR_ROWS       = 20;
   localparam int RAND_ITEMS     = 400;
   localparam int QUIET_ITEMS    = 60;    // final stretch sent without idling
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 200;   // covers map cleanup after a run

   typedef struct packed {
      logic [GENE_W-1:0]   gene_a;
      logic [GENE_W-1:0]   gene_b;
      logic [CUT_BITS-1:0] cut_first;
      logic [CUT_BITS-1:0] cut_second;
      logic                last;
   } gene_pair_type;

   typedef struct packed {
      logic [GENE_W-1:0] child_a;
      logic [GENE_W-1:0] child_b;
      logic              chain_err;
      logic              last;
   } child_word_type;

   // a row either types its result words in (n_typed > 0) or defers to the
   // predictor
   typedef struct packed {
      gene_pair_type  w;
      logic [1:0]     n_typed;
      child_word_type t0;
      child_word_type t1;
   } stim_row_type;

   localparam child_word_type NO_WORD = '0;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [GENE_W-1:0]   req_gene_a = '0;
   logic [GENE_W-1:0]   req_gene_b = '0;
   logic [CUT_BITS-1:0] req_cut_first = '0;
   logic [CUT_BITS-1:0] req_cut_second = '0;
   logic                req_last_gene = 1'b0;
   logic                rsp_valid;
   logic [GENE_W-1:0]   rsp_child_a_gene;
   logic [GENE_W-1:0]   rsp_child_b_gene;
   logic                rsp_chain_error;
   logic                rsp_last_child_gene;

   // predictor state
   logic [GENE_W-1:0] par_a [MAX_LEN];
   logic [GENE_W-1:0] par_b [MAX_LEN];
   logic [GENE_W-1:0] map_a_val [MAP_DEPTH];
   logic [GENE_W-1:0] map_b_val [MAP_DEPTH];
   bit                map_a_ok [MAP_DEPTH];
   bit                map_b_ok [MAP_DEPTH];
   int unsigned       n_loaded = 0;

   child_word_type run_words [$];      // words of the run just predicted
   child_word_type child_words_q [$];  // words still awaited from the block
   int unsigned fail_count = 0;
   int unsigned items_sent = 0;
   int unsigned stall_cycles = 0;
   bit          idle_on = 1'b1;

   stim_row_type dir_tab [DIR_ROWS] = '{
      // one pair, second cut far past the length
      {8'hFF, 8'h00, 6'd0,  6'd63, 1'b1, 2'd1, 8'hFF, 8'h00, 1'b0, 1'b1, NO_WORD},
      // one pair, both cuts clamped: empty segment
      {8'h00, 8'hFF, 6'd63, 6'd63, 1'b1, 2'd1, 8'hFF, 8'h00, 1'b0, 1'b1, NO_WORD},
      // gene mapped to itself: chain never ends, cuts given swapped
      {8'h05, 8'h05, 6'd63, 6'd63, 1'b0, 2'd0, NO_WORD, NO_WORD},
      {8'h05, 8'h05, 6'd2,  6'd1,  1'b1, 2'd2, 8'h05, 8'h05, 1'b0, 1'b0,
                                                8'h05, 8'h05, 1'b1, 1'b1},
      // reversed permutation, cuts on non-last words are ignored
      {8'h00, 8'h03, 6'h2A, 6'h15, 1'b0, 2'd0, NO_WORD, NO_WORD},
      {8'h01, 8'h02, 6'h00, 6'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
      {8'h02, 8'h01, 6'h3F, 6'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
      {8'h03, 8'h00, 6'd1,  6'd3,  1'b1, 2'd0, NO_WORD, NO_WORD},
      // duplicate genes in the segment overwrite map entries
      {8'h10, 8'h20, 6'h3F, 6'h2A, 1'b0, 2'd0, NO_WORD, NO_WORD},
      {8'h20, 8'h10, 6'h15, 6'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
      {8'h10, 8'h30, 6'h00, 6'h3F, 1'b0, 2'd0, NO_WORD, NO_WORD},
      {8'h30, 8'h10, 6'h2A, 6'h15, 1'b0, 2'd0, NO_WORD, NO_WORD},
      {8'h20, 8'h40, 6'd4,  6'd1,  1'b1, 2'd0, NO_WORD, NO_WORD},
      // all-zero genes, whole length as segment
      {8'h00, 8'h00, 6'h3F, 6'h3F, 1'b0, 2'd0, NO_WORD, NO_WORD},
      {8'h00, 8'h00, 6'h00, 6'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
      {8'h00, 8'h00, 6'd3,  6'd0,  1'b1, 2'd0, NO_WORD, NO_WORD},
      // map chain across the top gene
      {8'h80, 8'hFF, 6'h00, 6'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
      {8'hFF, 8'h80, 6'd0,  6'd1,  1'b1, 2'd0, NO_WORD, NO_WORD},
      // alternating bits, swapped cuts clamped to the whole length
      {8'hAA, 8'h55, 6'h3F, 6'h3F, 1'b0, 2'd0, NO_WORD, NO_WORD},
      {8'h55, 8'hAA, 6'd63, 6'd0,  1'b1, 2'd0, NO_WORD, NO_WORD}
   };

   pmx_crossover #(
      .MAX_LEN   (MAX_LEN),
      .GENE_BITS (GENE_W)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_gene_a          (req_gene_a),
      .req_gene_b          (req_gene_b),
      .req_cut_first       (req_cut_first),
      .req_cut_second      (req_cut_second),
      .req_last_gene       (req_last_gene),
      .rsp_valid           (rsp_valid),
      .rsp_child_a_gene    (rsp_child_a_gene),
      .rsp_child_b_gene    (rsp_child_b_gene),
      .rsp_chain_error     (rsp_chain_error),
      .rsp_last_child_gene (rsp_last_child_gene)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // follow one map from g until unmapped, giving up after len steps;
   // returns {chain error, gene reached}
   function automatic logic [GENE_W:0] follow_chain(input bit via_b,
                                                    input logic [GENE_W-1:0] g,
                                                    input int unsigned len);
      int unsigned       steps;
      logic [GENE_W-1:0] cur;
      steps = 0;
      cur = g;
      while (via_b ? map_b_ok[cur] : map_a_ok[cur]) begin
         if (steps >= len)
            return {1'b1, cur};
         cur = via_b ? map_b_val[cur] : map_a_val[cur];
         steps++;
      end
      return {1'b0, cur};
   endfunction

   // load one pair; on the last word compute the children into run_words
   function automatic void breed_children(input gene_pair_type w);
      int unsigned       len, lo, hi, i, k;
      logic [GENE_W:0]   ra, rb;
      child_word_type    cw;
      run_words.delete();
      if (n_loaded < MAX_LEN) begin
         par_a[n_loaded] = w.gene_a;
         par_b[n_loaded] = w.gene_b;
         n_loaded++;
      end
      if (!w.last)
         return;

      len = n_loaded;
      lo = 32'(w.cut_first);
      hi = 32'(w.cut_second);
      if (lo > hi) begin
         k = lo;
         lo = hi;
         hi = k;
      end
      if (lo > len) lo = len;
      if (hi > len) hi = len;

      // maps from the segment; later positions win
      for (i = lo; i < hi; i++) begin
         map_a_val[par_b[i]] = par_a[i];
         map_a_ok[par_b[i]]  = 1'b1;
         map_b_val[par_a[i]] = par_b[i];
         map_b_ok[par_a[i]]  = 1'b1;
      end

      // segment first, then outside positions through the map chains
      k = 0;
      for (i = lo; i < hi; i++) begin
         cw = {par_a[i], par_b[i], 1'b0, 1'(k + 1 == len)};
         run_words = {run_words, cw};
         k++;
      end
      for (i = 0; i < len; i++) begin
         if (i < lo || i >= hi) begin
            ra = follow_chain(1'b1, par_b[i], len);
            rb = follow_chain(1'b0, par_a[i], len);
            cw = {ra[GENE_W-1:0], rb[GENE_W-1:0], ra[GENE_W] | rb[GENE_W],
                  1'(k + 1 == len)};
            run_words = {run_words, cw};
            k++;
         end
      end

      for (i = 0; i < MAP_DEPTH; i++) begin
         map_a_ok[i] = 1'b0;
         map_b_ok[i] = 1'b0;
      end
      n_loaded = 0;
   endfunction

   // present one request word, wait for it to be taken, record expectations
   task automatic send_word(input gene_pair_type w, input int unsigned n_typed,
                            input child_word_type t0, input child_word_type t1);
      int unsigned gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_gene_a     <= w.gene_a;
      req_gene_b     <= w.gene_b;
      req_cut_first  <= w.cut_first;
      req_cut_second <= w.cut_second;
      req_last_gene  <= w.last;
      start          <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);

      breed_children(w);
      if (n_typed > 0) begin
         child_words_q = {child_words_q, t0};
         if (n_typed > 1)
            child_words_q = {child_words_q, t1};
      end else begin
         foreach (run_words[j])
            child_words_q = {child_words_q, run_words[j]};
      end
      items_sent++;
   endtask

   // one run of len pairs; noisy runs break the permutation property
   task automatic send_run(input int unsigned len, input bit noisy);
      logic [GENE_W-1:0] pa [128];
      logic [GENE_W-1:0] pb [128];
      bit                taken [MAP_DEPTH];
      logic [GENE_W-1:0] g;
      int unsigned       i, j, span;
      gene_pair_type     w;
      foreach (taken[m])
         taken[m] = 1'b0;
      for (i = 0; i < len; i++) begin
         do g = GENE_W'($urandom_range(0, MAP_DEPTH - 1)); while (taken[g]);
         taken[g] = 1'b1;
         pa[i] = g;
         pb[i] = g;
      end
      // shuffle both parents independently
      for (i = len - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         g = pa[i]; pa[i] = pa[j]; pa[j] = g;
         j = $urandom_range(0, i);
         g = pb[i]; pb[i] = pb[j]; pb[j] = g;
      end
      if (noisy) begin
         for (i = 0; i < len; i++)
            if ($urandom_range(0, 2) == 0)
               pb[i] = GENE_W'($urandom_range(0, MAP_DEPTH - 1));
      end

      for (i = 0; i < len; i++) begin
         w.gene_a = pa[i];
         w.gene_b = pb[i];
         w.last   = (i == len - 1);
         if (w.last && $urandom_range(0, 3) != 0)
            span = (len + 1 < 63) ? len + 1 : 63;
         else
            span = 63;
         w.cut_first  = CUT_BITS'($urandom_range(0, span));
         w.cut_second = CUT_BITS'($urandom_range(0, span));
         send_word(w, 0, NO_WORD, NO_WORD);
      end
   endtask

   // stop sending until every awaited word has arrived
   task automatic hold_until_drained();
      @(negedge clock);
      start <= 1'b0;
      while (child_words_q.size() != 0) @(posedge clock);
   endtask

   // result checking and watchdog
   always @(posedge clock) begin : check_words
      child_word_type exp_w;
      if (!reset && rsp_valid === 1'b1) begin
         if (child_words_q.size() == 0) begin
            $error("unexpected result word: child_a_gene %0h child_b_gene %0h",
                   rsp_child_a_gene, rsp_child_b_gene);
            fail_count++;
         end else begin
            exp_w = child_words_q.pop_front();
            if (rsp_child_a_gene !== exp_w.child_a) begin
               $error("child_a_gene: expected %0h, actual %0h",
                      exp_w.child_a, rsp_child_a_gene);
               fail_count++;
            end
            if (rsp_child_b_gene !== exp_w.child_b) begin
               $error("child_b_gene: expected %0h, actual %0h",
                      exp_w.child_b, rsp_child_b_gene);
               fail_count++;
            end
            if (rsp_chain_error !== exp_w.chain_err) begin
               $error("chain_error: expected %0b, actual %0b",
                      exp_w.chain_err, rsp_chain_error);
               fail_count++;
            end
            if (rsp_last_child_gene !== exp_w.last) begin
               $error("last_child_gene: expected %0b, actual %0b",
                      exp_w.last, rsp_last_child_gene);
               fail_count++;
            end
         end
      end

      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      int unsigned r, len;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < DIR_ROWS; i++)
         send_word(dir_tab[i].w, dir_tab[i].n_typed, dir_tab[i].t0, dir_tab[i].t1);
      hold_until_drained();

      // store overflow, full length, full length with broken parents
      send_run(66, 1'b0);
      send_run(MAX_LEN, 1'b0);
      send_run(MAX_LEN, 1'b1);

      // random runs, mostly short
      while (items_sent < DIR_ROWS + RAND_ITEMS) begin
         idle_on = (items_sent < DIR_ROWS + RAND_ITEMS - QUIET_ITEMS) &&
                   ($urandom_range(0, 2) != 0);
         r = $urandom_range(0, 19);
         if (r == 0)
            len = $urandom_range(MAX_LEN + 1, MAX_LEN + 8);
         else if (r < 4)
            len = $urandom_range(13, MAX_LEN);
         else
            len = $urandom_range(1, 12);
         send_run(len, $urandom_range(0, 4) == 0);
         if ($urandom_range(0, 7) == 0)
            hold_until_drained();
      end

      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/pmx_pkg.sv
src/pmx_map_ram.sv
src/pmx_crossover.sv
test/tb.sv
